[rtl/core/tnri_pkg.sv]
package tnri_pkg;

  localparam int NODE_W     = 8;
  localparam int ORDER_W    = 4;
  localparam int FLIP_W     = 3;
  localparam int ROT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [ORDER_W-1:0] DEGREE_RST = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE     = 2'd0,
    REG_FLIP_COUNT = 2'd1,
    REG_ROT_COUNT  = 2'd2
  } tnri_reg_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } tnri_alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAYER,
    ST_EDGE,
    ST_DIV,
    ST_MUL,
    ST_ADDI,
    ST_FIN
  } tnri_state_t;

  // rotation count modulo 3
  function automatic logic [1:0] mod3(input logic [ROT_W-1:0] r);
    logic [1:0] m;
    unique case (r)
      3'd0, 3'd3, 3'd6: m = 2'd0;
      3'd1, 3'd4, 3'd7: m = 2'd1;
      default:          m = 2'd2;
    endcase
    return m;
  endfunction

  // v -> (v+2) mod 3, applied r times
  function automatic logic [1:0] rot3(input logic [1:0] v, input logic [1:0] r);
    logic [2:0] s;
    logic [2:0] m;
    s = {1'b0, v} + {r, 1'b0};
    if (s >= 3'd6) begin
      m = s - 3'd6;
    end else if (s >= 3'd3) begin
      m = s - 3'd3;
    end else begin
      m = s;
    end
    return m[1:0];
  endfunction

  // vertices 0 and 1 swap
  function automatic logic [1:0] flip_vertex(input logic [1:0] v);
    logic [1:0] f;
    unique case (v)
      2'd0:    f = 2'd1;
      2'd1:    f = 2'd0;
      default: f = 2'd2;
    endcase
    return f;
  endfunction

  // edges 1 and 2 swap
  function automatic logic [1:0] flip_edge(input logic [1:0] e);
    logic [1:0] f;
    unique case (e)
      2'd1:    f = 2'd2;
      2'd2:    f = 2'd1;
      default: f = 2'd0;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/tnri_in_if.sv]
interface tnri_in_if;
  import tnri_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface

[rtl/core/tnri_out_if.sv]
interface tnri_out_if;
  import tnri_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] source_index;
  logic              index_error;

  modport source (output valid, output source_index, output index_error, input ready);
  modport sink   (input valid, input source_index, input index_error, output ready);
endinterface

[rtl/core/tnri_cfg_if.sv]
interface tnri_cfg_if;
  import tnri_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/tnri_alu.sv]
module tnri_alu #(
  parameter int W = 8
) (
  input  logic [W-1:0]           a,
  input  logic [W-1:0]           b,
  input  tnri_pkg::tnri_alu_op_t op,
  output logic [W-1:0]           res,
  output logic                   borrow
);
  import tnri_pkg::*;

  logic [W:0] full;

  always_comb begin
    unique case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = {1'b0, a};
    endcase
  end

  assign res    = full[W-1:0];
  // a < b on subtract
  assign borrow = (op == ALU_SUB) ? full[W] : 1'b0;

endmodule

[rtl/core/triangle_node_realign_index.sv]
// Realigned node index of an equidistant triangle in layer-by-layer node order. Each item
// is one node_index; the result is the original node index that lands there after
// rotation_count mod 3 rotations and flip_count mod 2 flips, or the index itself with
// index_error set when it is not below the node count of the configured order (saturated
// at MAX_ORDER). An out-of-range item goes straight to the output step; a result may also
// wait for a full output register. A small sequencer drives a single shared add/subtract
// unit through the layer search (one layer a cycle), the split of an edge position into
// edge and slot, the edge offset and the final add. The block is busy for one item at a
// time; a finished result sits in an output register, so the next item is taken while it
// waits. Configuration writes are always ready; the user is to make them only while the
// block is idle, which the block itself does not enforce.
module triangle_node_realign_index #(
  parameter int MAX_ORDER = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  tnri_in_if.sink    in_ch,
  tnri_out_if.source out_ch,
  tnri_cfg_if.sink   cfg_ch
);
  import tnri_pkg::*;

  localparam int TOTAL_MAX = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
  localparam int TW        = $clog2(TOTAL_MAX + 1);
  localparam int CW        = (TW > NODE_W) ? TW : NODE_W;
  localparam int QW        = $clog2(MAX_ORDER + 1);

  // configuration
  logic [ORDER_W-1:0] degree_r;
  logic [FLIP_W-1:0]  flip_count_r;
  logic [ROT_W-1:0]   rot_count_r;

  // sequencer
  tnri_state_t state_r, state_nxt;
  logic [NODE_W-1:0] j_r, j_nxt;
  logic              err_r, err_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     off_r, off_nxt;
  logic [CW-1:0]     s_r, s_nxt;
  logic [CW-1:0]     acc_r, acc_nxt;
  logic [CW-1:0]     addend_r, addend_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [1:0]        e_r, e_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_src_r, out_src_nxt;
  logic              out_err_r, out_err_nxt;

  // shared unit
  logic [CW-1:0] alu_a, alu_b, alu_res;
  logic          alu_borrow;
  tnri_alu_op_t  alu_op;

  // derived
  logic [QW-1:0]     psat;
  logic [QW:0]       p1, p2;
  logic [2*QW+1:0]   tot_prod;
  logic [CW-1:0]     total;
  logic [CW-1:0]     s_init;
  logic [1:0]        rots;
  logic              flip;
  logic [QW-1:0]     n;
  logic [CW-1:0]     n_cw;
  logic [1:0]        v_rot, e_rot;
  logic [QW-1:0]     i_raw, i_fin;
  logic              in_fire;

  tnri_alu #(.W(CW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r     <= DEGREE_RST;
      flip_count_r <= '0;
      rot_count_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_DEGREE:     degree_r     <= cfg_ch.wdata[ORDER_W-1:0];
        REG_FLIP_COUNT: flip_count_r <= cfg_ch.wdata[FLIP_W-1:0];
        REG_ROT_COUNT:  rot_count_r  <= cfg_ch.wdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(degree_r) > MAX_ORDER) begin
      psat = QW'(MAX_ORDER);
    end else begin
      psat = QW'(degree_r);
    end
    p1       = {1'b0, psat} + (QW+1)'(1);
    p2       = {1'b0, psat} + (QW+1)'(2);
    tot_prod = {{(QW+1){1'b0}}, p1} * {{(QW+1){1'b0}}, p2};
    total    = CW'(tot_prod >> 1);
    s_init   = (CW'(psat) << 1) + CW'(psat);
  end

  assign rots    = mod3(rot_count_r);
  assign flip    = flip_count_r[0];
  assign n       = q_r - QW'(1);
  assign n_cw    = CW'(n);
  assign v_rot   = rot3(rem_r[1:0], rots);
  assign e_rot   = rot3(e_r, rots);
  assign i_raw   = rem_r[QW-1:0];
  assign i_fin   = flip ? (n - QW'(1) - i_raw) : i_raw;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.source_index = out_src_r;
  assign out_ch.index_error  = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    err_r     <= err_nxt;
    rem_r     <= rem_nxt;
    off_r     <= off_nxt;
    s_r       <= s_nxt;
    acc_r     <= acc_nxt;
    addend_r  <= addend_nxt;
    q_r       <= q_nxt;
    e_r       <= e_nxt;
    cnt_r     <= cnt_nxt;
    out_src_r <= out_src_nxt;
    out_err_r <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    err_nxt       = err_r;
    rem_nxt       = rem_r;
    off_nxt       = off_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    addend_nxt    = addend_r;
    q_nxt         = q_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    out_src_nxt   = out_src_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    alu_a         = rem_r;
    alu_b         = s_r;
    alu_op        = ALU_SUB;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          j_nxt   = in_ch.node_index;
          err_nxt = (CW'(in_ch.node_index) >= total);
          rem_nxt = CW'(in_ch.node_index);
          off_nxt = '0;
          q_nxt   = psat;
          s_nxt   = s_init;
          acc_nxt = CW'(in_ch.node_index);
          if (CW'(in_ch.node_index) >= total) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LAYER;
          end
        end
      end

      // one onion layer a cycle
      ST_LAYER: begin
        alu_a = rem_r;
        alu_b = s_r;
        if (q_r == '0) begin
          acc_nxt   = CW'(j_r);
          state_nxt = ST_FIN;
        end else if (alu_borrow) begin
          state_nxt = ST_EDGE;
        end else begin
          rem_nxt = alu_res;
          off_nxt = off_r + s_r;
          q_nxt   = (int'(q_r) > 3) ? (q_r - QW'(3)) : '0;
          s_nxt   = (s_r > CW'(9)) ? (s_r - CW'(9)) : '0;
        end
      end

      // vertex or edge node
      ST_EDGE: begin
        alu_a = rem_r;
        alu_b = CW'(3);
        if (alu_borrow) begin
          acc_nxt    = off_r;
          addend_nxt = CW'(flip ? flip_vertex(v_rot) : v_rot);
          state_nxt  = ST_ADDI;
        end else if (n == '0) begin
          acc_nxt   = CW'(j_r);
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = alu_res;
          e_nxt     = 2'd0;
          state_nxt = ST_DIV;
        end
      end

      // edge and slot by repeated subtract
      ST_DIV: begin
        alu_a = rem_r;
        alu_b = n_cw;
        if (alu_borrow) begin
          acc_nxt    = off_r;
          addend_nxt = CW'(i_fin) + CW'(3);
          cnt_nxt    = flip ? flip_edge(e_rot) : e_rot;
          state_nxt  = ST_MUL;
        end else begin
          rem_nxt = alu_res;
          e_nxt   = e_r + 2'd1;
        end
      end

      // edge offset by repeated add
      ST_MUL: begin
        alu_a  = acc_r;
        alu_b  = n_cw;
        alu_op = ALU_ADD;
        if (cnt_r == 2'd0) begin
          state_nxt = ST_ADDI;
        end else begin
          acc_nxt = alu_res;
          cnt_nxt = cnt_r - 2'd1;
        end
      end

      ST_ADDI: begin
        alu_a     = acc_r;
        alu_b     = addend_r;
        alu_op    = ALU_ADD;
        acc_nxt   = alu_res;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = acc_r[NODE_W-1:0];
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_err_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && err_r) |-> (acc_r[NODE_W-1:0] == j_r))
    else $error("out-of-range item not passed through");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ch.ready) |=> (state_r == ST_FIN))
    else $error("result dropped while output register full");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (e_r <= 2'd2))
    else $error("edge number beyond two");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire) |=> (state_r == ST_LAYER || state_r == ST_FIN))
    else $error("item accepted without starting the search");

endmodule

[verif/tb_triangle_node_realign_index.sv]
module tb_triangle_node_realign_index;
  import tnri_pkg::*;

  localparam int MAX_ORDER   = 15;
  localparam int SETTLE      = 24;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [NODE_W-1:0] source_index;
    logic              index_error;
  } node_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tnri_in_if  in_if();
  tnri_out_if out_if();
  tnri_cfg_if cfg_if();

  triangle_node_realign_index #(.MAX_ORDER(MAX_ORDER)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  logic [ORDER_W-1:0] cur_order = DEGREE_RST;
  logic [FLIP_W-1:0]  cur_flips = '0;
  logic [ROT_W-1:0]   cur_rots  = '0;

  node_result_t pending_sources[$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int rx_left        = 0;
  int rx_mode        = 0;

  // original node index that lands at position idx
  function automatic node_result_t realigned_source(input logic [ORDER_W-1:0] order_reg,
                                                    input logic [FLIP_W-1:0]  flips_reg,
                                                    input logic [ROT_W-1:0]   rots_reg,
                                                    input logic [NODE_W-1:0]  idx);
    int p, q, off, loc, n, v, e, slot, rots;
    bit flip;
    node_result_t r;
    p    = int'(order_reg);
    rots = int'(rots_reg) % 3;
    flip = flips_reg[0];
    r.source_index = idx;
    r.index_error  = 1'b0;
    if (p > MAX_ORDER) begin
      p = MAX_ORDER;
    end
    if (int'(idx) >= (p + 1) * (p + 2) / 2) begin
      r.index_error = 1'b1;
      return r;
    end
    off = 0;
    q   = p;
    while (q > 0 && int'(idx) >= off + 3 * q) begin
      off += 3 * q;
      q   -= 3;
    end
    if (q <= 0) begin
      return r;
    end
    loc = int'(idx) - off;
    n   = q - 1;
    if (loc < 3) begin
      v = loc;
      repeat (rots) v = (v + 2) % 3;
      if (flip) begin
        v = (v < 2) ? 1 - v : 2;
      end
      r.source_index = NODE_W'(off + v);
    end else if (n != 0) begin
      e    = (loc - 3) / n;
      slot = (loc - 3) % n;
      if (e <= 2) begin
        repeat (rots) e = (e + 2) % 3;
        if (flip) begin
          e    = (e == 0) ? 0 : 3 - e;
          slot = n - 1 - slot;
        end
        r.source_index = NODE_W'(off + 3 + e * n + slot);
      end
    end
    return r;
  endfunction

  function automatic int node_total(input logic [ORDER_W-1:0] order_reg);
    int p;
    p = (int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
    return (p + 1) * (p + 2) / 2;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // entered and left at a falling edge
  task automatic send_node(input logic [NODE_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_if.valid      <= 1'b1;
    in_if.node_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    pending_sources.push_back(realigned_source(cur_order, cur_flips, cur_rots, idx));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic end_stream();
    in_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    while (pending_sources.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input tnri_reg_t which, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= which;
    cfg_if.wdata     <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (which)
      REG_DEGREE:     cur_order = value[ORDER_W-1:0];
      REG_FLIP_COUNT: cur_flips = value[FLIP_W-1:0];
      REG_ROT_COUNT:  cur_rots  = value[ROT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input int order, input int flips, input int rots);
    write_reg(REG_DEGREE, CFG_DATA_W'(order));
    write_reg(REG_FLIP_COUNT, CFG_DATA_W'(flips));
    write_reg(REG_ROT_COUNT, CFG_DATA_W'(rots));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_node(8'd0);
    send_node(8'd1);
    send_node(8'd2);
    send_node(8'd3);
    send_node(8'd255);
    end_stream();
    wait_idle();
  endtask

  task automatic test_order_extremes();
    set_config(0, 0, 0);
    send_node(8'd0);
    send_node(8'd1);
    end_stream();
    wait_idle();
    // innermost layer of order 15 starts at 126, centre node at 135
    set_config(15, 1, 1);
    send_node(8'd0);
    send_node(8'd126);
    send_node(8'd134);
    send_node(8'd135);
    send_node(8'd136);
    send_node(8'd255);
    end_stream();
    wait_idle();
    // order 4: inner layer of order 1 has vertices only
    set_config(4, 7, 5);
    send_node(8'd11);
    send_node(8'd12);
    send_node(8'd13);
    send_node(8'd14);
    end_stream();
    wait_idle();
  endtask

  task automatic test_rotation_flip();
    set_config(3, 7, 4);
    for (int i = 0; i < 10; i++) begin
      send_node(i[NODE_W-1:0]);
    end
    end_stream();
    wait_idle();
  endtask

  task automatic test_random_configs();
    int total;
    for (int ph = 0; ph < 15; ph++) begin
      case (ph)
        0:       set_config(15, 7, 7);
        1:       set_config(0, 0, 0);
        2:       set_config(15, 6, 3);
        3:       set_config(1, 1, 2);
        default: set_config($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7));
      endcase
      total = node_total(cur_order);
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_node(NODE_W'($urandom_range(0, 255)));
        end else begin
          send_node(NODE_W'($urandom_range(0, total - 1)));
        end
      end
      end_stream();
      wait_idle();
    end
  endtask

  // receiver stall pattern: free-running, random, or held off
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 24);
    end
    rx_left--;
    case (rx_mode)
      0, 1:    out_if.ready <= 1'b1;
      2:       out_if.ready <= 1'($urandom_range(0, 1));
      default: out_if.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    node_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_sources.size() == 0) begin
        report_mismatch("unexpected item, source_index", out_if.source_index, -1);
      end else begin
        want = pending_sources.pop_front();
        if (out_if.source_index !== want.source_index) begin
          report_mismatch("source_index", out_if.source_index, want.source_index);
        end
        if (out_if.index_error !== want.index_error) begin
          report_mismatch("index_error", out_if.index_error, want.index_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.node_index = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_DEGREE;
    cfg_if.wdata     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_order_extremes();
    test_rotation_flip();
    test_random_configs();

    if (mismatch_count == 0 && pending_sources.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
